/* sv/ltfce_pkg.sv */
// Package for the LTF channel estimate / SNR unit: request and result structs,
// training sign table and fixed constants. No dependencies.
package ltfce_pkg;

  localparam int unsigned CarrierBits = 6;
  localparam int unsigned SumBits     = 40;
  localparam int unsigned DbScale     = 197283;
  localparam logic [CarrierBits-1:0] FirstCounted = 6'd6;
  localparam logic [CarrierBits-1:0] LastCounted  = 6'd58;
  localparam logic [CarrierBits-1:0] DcCarrier    = 6'd32;

  typedef struct packed {
    logic              req_type;
    logic [5:0]        carrier;
    logic signed [15:0] sample_re;
    logic signed [15:0] sample_im;
    logic              last_carrier;
  } req_t;

  typedef struct packed {
    logic [5:0]         est_carrier;
    logic signed [15:0] est_re;
    logic signed [15:0] est_im;
    logic signed [15:0] snr_db;
    logic signed [15:0] snr_min_db;
    logic signed [15:0] snr_max_db;
    logic               done_res;
    logic               noise_zero;
  } res_t;

  // Training sign: 2'b00 zero, 2'b01 plus, 2'b11 minus.
  function automatic logic [1:0] train_sign(input logic [5:0] c);
    logic [63:0] nz;
    logic [63:0] neg;
    nz  = 64'h07FF_FFFE_FFFF_FFC0;
    neg = 64'h0056_7D4C_0A60_5300;
    train_sign = {neg[c], nz[c]};
  endfunction

endpackage

/* sv/ltf_channel_estimate_snr_unit.sv */
// Top level of the LTF channel estimate / SNR unit.
// Depends on ltfce_pkg, ltfce_store and ltfce_log.
//
// A first-symbol request is written straight into the store and busy stays low.
// A second-symbol request holds busy through S_READ, S_SQ, S_XP and S_ACC:
// squares of sum and difference, cross products, compare and accumulate, then
// the estimate is registered; for a non-last carrier valid_o rises as busy falls.
// On a last-carrier request each of the three dB values needs two log2
// evaluations (signal, then noise) through the shared serial log unit,
// followed by dB scaling and rounding; a final state loads the result, and
// busy stays high throughout. The result strobe valid_o is high one cycle; the
// receiver cannot stall it.
module ltf_channel_estimate_snr_unit #(
  parameter int unsigned LOG_FRAC_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ltfce_pkg::req_t   req_i,
  output logic              valid_o,
  output ltfce_pkg::res_t   res_o
);
  localparam int unsigned LW = 6 + LOG_FRAC_BITS;
  localparam int unsigned Sh = LOG_FRAC_BITS + 8;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_SQ, S_XP, S_ACC, S_LOGGO, S_LOGWT, S_MUL, S_RND, S_OUT
  } state_e;

  state_e state_q;
  ltfce_pkg::req_t r_q;
  logic [31:0] rdata;
  logic [39:0] sig_sum_q, noi_sum_q;
  logic [33:0] mins_q, minn_q, maxs_q, maxn_q, sig_q, noi_q;
  logic        started_q;
  logic signed [17:0] pr, pi, dr, di;
  logic [67:0] p1_q, p2_q, p3_q, p4_q;
  logic [39:0] lx;
  logic        lstart, ldone;
  logic [LW-1:0] lval, ls_q;
  logic signed [LW+1:0] diff_q;
  logic signed [LW+20:0] prod_q;
  logic signed [15:0] db_q [3];
  logic        zero_n_q, zero_s_q;
  logic [1:0]  ix_q;
  ltfce_pkg::res_t res_q;
  logic        valid_q;

  // Hold the samples of the first symbol per carrier.
  ltfce_store #(.Width(32)) u_store (
    .clk_i, .we_i(start && !busy && !req_i.req_type), .waddr_i(req_i.carrier),
    .wdata_i({req_i.sample_re, req_i.sample_im}),
    .re_i(start && !busy && req_i.req_type), .raddr_i(req_i.carrier),
    .rdata_o(rdata));

  ltfce_log #(.FracBits(LOG_FRAC_BITS)) u_log (
    .clk_i, .rst_ni, .start_i(lstart), .x_i(lx), .done_o(ldone), .log_o(lval));

  assign busy = (state_q != S_IDLE);
  assign lstart = (state_q == S_LOGGO);

  logic signed [15:0] hr, hi;
  assign hr = rdata[31:16];
  assign hi = rdata[15:0];
  assign pr = 18'(hr) + 18'(r_q.sample_re);
  assign pi = 18'(hi) + 18'(r_q.sample_im);
  assign dr = 18'(hr) - 18'(r_q.sample_re);
  assign di = 18'(hi) - 18'(r_q.sample_im);

  logic counted;
  assign counted = r_q.carrier >= ltfce_pkg::FirstCounted &&
                   r_q.carrier <= ltfce_pkg::LastCounted &&
                   r_q.carrier != ltfce_pkg::DcCarrier;

  // Select the operand for the shared log unit: 0/1 total, 2/3 min, 4/5 max.
  logic [2:0] lop_q;
  always_comb begin
    case (lop_q)
      3'd0:    lx = sig_sum_q;
      3'd1:    lx = noi_sum_q;
      3'd2:    lx = 40'(mins_q);
      3'd3:    lx = 40'(minn_q);
      3'd4:    lx = 40'(maxs_q);
      default: lx = 40'(maxn_q);
    endcase
  end

  // Estimate: floor half sum, sign flip, saturate; zero on null carriers.
  function automatic logic signed [15:0] est(input logic signed [17:0] s,
                                             input logic [1:0] sg);
    logic signed [17:0] h;
    h = s >>> 1;
    if (sg[1]) h = -h;
    if (!sg[0]) est = '0;
    else if (h > 18'sd32767) est = 16'sh7fff;
    else est = h[15:0];
  endfunction

  logic signed [15:0] er_q, ei_q;
  logic [40:0] sa, na;
  assign sa = 41'(sig_sum_q) + 41'(sig_q);
  assign na = 41'(noi_sum_q) + 41'(noi_q);

  logic signed [LW+20:0] half, rnd;
  assign half = (LW+21)'(1) <<< (Sh - 1);
  assign rnd  = prod_q[LW+20] ? -((-prod_q + half) >>> Sh) : ((prod_q + half) >>> Sh);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      valid_q   <= 1'b0;
      started_q <= 1'b0;
      sig_sum_q <= '0; noi_sum_q <= '0;
      mins_q <= '0; minn_q <= '0; maxs_q <= '0; maxn_q <= '0;
      lop_q <= '0; ix_q <= '0;
    end else begin
      // Strobe the result when the estimate or the dB values are loaded.
      valid_q <= ((state_q == S_ACC) && !r_q.last_carrier) || (state_q == S_OUT);
      unique case (state_q)
        S_IDLE: if (start && req_i.req_type) begin
          r_q <= req_i; state_q <= S_READ;
        end
        S_READ: begin
          sig_q <= 34'(pr) * 34'(pr) + 34'(pi) * 34'(pi);
          noi_q <= 34'(dr) * 34'(dr) + 34'(di) * 34'(di);
          er_q <= est(pr, ltfce_pkg::train_sign(r_q.carrier));
          ei_q <= est(pi, ltfce_pkg::train_sign(r_q.carrier));
          state_q <= S_SQ;
        end
        S_SQ: begin
          p1_q <= 68'(mins_q) * 68'(noi_q);
          p2_q <= 68'(sig_q) * 68'(minn_q);
          p3_q <= 68'(sig_q) * 68'(maxn_q);
          p4_q <= 68'(maxs_q) * 68'(noi_q);
          state_q <= S_XP;
        end
        S_XP: begin
          if (counted) begin
            sig_sum_q <= sa[40] ? '1 : sa[39:0];
            noi_sum_q <= na[40] ? '1 : na[39:0];
            if (!started_q || p1_q >= p2_q) begin mins_q <= sig_q; minn_q <= noi_q; end
            if (!started_q || p3_q >= p4_q) begin maxs_q <= sig_q; maxn_q <= noi_q; end
            started_q <= 1'b1;
          end
          state_q <= S_ACC;
        end
        S_ACC: begin
          res_q <= ltfce_pkg::res_t'{
            est_carrier: r_q.carrier, est_re: er_q, est_im: ei_q,
            snr_db: '0, snr_min_db: '0, snr_max_db: '0,
            done_res: r_q.last_carrier,
            noise_zero: r_q.last_carrier && (noi_sum_q == '0)};
          if (r_q.last_carrier) begin
            lop_q <= '0; ix_q <= '0; state_q <= S_LOGGO;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_LOGGO: state_q <= S_LOGWT;
        S_LOGWT: if (ldone) begin
          if (!lop_q[0]) begin
            ls_q <= lval; lop_q <= lop_q + 3'd1; state_q <= S_LOGGO;
          end else begin
            zero_s_q <= (lop_q == 3'd1) ? sig_sum_q == '0 :
                        (lop_q == 3'd3) ? mins_q == '0 : maxs_q == '0;
            zero_n_q <= (lop_q == 3'd1) ? noi_sum_q == '0 :
                        (lop_q == 3'd3) ? minn_q == '0 : maxn_q == '0;
            diff_q <= (LW+2)'(ls_q) - (LW+2)'(lval) - ((LW+2)'(1) << LOG_FRAC_BITS);
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q <= (LW+21)'(diff_q) * (LW+21)'(ltfce_pkg::DbScale);
          state_q <= S_RND;
        end
        S_RND: begin
          if (zero_n_q) db_q[ix_q] <= 16'sh7fff;
          else if (zero_s_q) db_q[ix_q] <= -16'sh8000;
          else if (rnd > (LW+21)'(32767)) db_q[ix_q] <= 16'sh7fff;
          else if (rnd < -(LW+21)'(32768)) db_q[ix_q] <= -16'sh8000;
          else db_q[ix_q] <= rnd[15:0];
          if (ix_q == 2'd2) state_q <= S_OUT;
          else begin
            ix_q <= ix_q + 2'd1; lop_q <= lop_q + 3'd1; state_q <= S_LOGGO;
          end
        end
        S_OUT: begin
          res_q <= ltfce_pkg::res_t'{
            est_carrier: res_q.est_carrier, est_re: res_q.est_re,
            est_im: res_q.est_im, snr_db: db_q[0], snr_min_db: db_q[1],
            snr_max_db: db_q[2], done_res: res_q.done_res,
            noise_zero: res_q.noise_zero};
          // Clear the sums and extremes for the next symbol pair.
          sig_sum_q <= '0; noi_sum_q <= '0;
          mins_q <= '0; minn_q <= '0; maxs_q <= '0; maxn_q <= '0;
          started_q <= 1'b0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

  a_one_shot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("result strobe held");
  a_done_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !res_o.done_res |-> !res_o.noise_zero) else $error("stray noise flag");
  a_busy_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy) else $error("result while busy");
endmodule

/* sv/ltfce_log.sv */
// Iterative log2 unit for the LTF channel estimate / SNR unit.
// Finds msb index, then one fraction bit per cycle by mantissa squaring.
// Uses ltfce_pkg.
module ltfce_log #(
  parameter int unsigned FracBits = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ltfce_pkg::SumBits-1:0] x_i,
  output logic                          done_o,
  output logic [5+FracBits:0]           log_o
);
  localparam int unsigned CntBits = $clog2(FracBits + 1);

  logic [30:0]         m_q, m_d;
  logic [5:0]          p_q, p_d;
  logic [FracBits-1:0] f_q, f_d;
  logic [CntBits-1:0]  n_q, n_d;
  logic                run_q, run_d, done_q, done_d;
  logic [61:0]         sq;
  logic [31:0]         msq;
  logic [5:0]          msb;
  logic [ltfce_pkg::SumBits+29:0] xs;

  always_comb begin
    msb = '0;
    for (int i = 0; i < int'(ltfce_pkg::SumBits); i++) begin
      if (x_i[i]) msb = 6'(i);
    end
  end

  assign xs  = {30'd0, x_i} << 30;
  assign sq  = m_q * m_q;
  assign msq = sq[61:30];

  always_comb begin
    m_d = m_q; p_d = p_q; f_d = f_q; n_d = n_q; run_d = run_q; done_d = 1'b0;
    if (start_i) begin
      p_d   = msb;
      m_d   = xs[msb +: 31];
      f_d   = '0;
      n_d   = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      f_d = {f_q[FracBits-2:0], msq[31]};
      m_d = msq[31] ? msq[31:1] : msq[30:0];
      n_d = n_q + 1'b1;
      if (n_q == CntBits'(FracBits - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      n_q    <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      n_q    <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q <= m_d;
    p_q <= p_d;
    f_q <= f_d;
  end

  assign done_o = done_q;
  assign log_o  = {p_q, f_q};
endmodule

/* sv/ltfce_store.sv */
// First-symbol sample memory for the LTF channel estimate / SNR unit.
// One write port, one registered read port. Uses no package items.
module ltfce_store #(
  parameter int unsigned Width = 32
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [5:0]       waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [5:0]       raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [64];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end
endmodule
